### design/pctc_pkg.sv
// ---------------------------------------------------------------------------
// pctc_pkg
// Shared widths and defaults for the packet checksum and time checker.
// ---------------------------------------------------------------------------
package pctc_pkg;

   localparam int MAX_BYTES_DEFAULT = 1024;

   localparam int SOD_W  = 18;
   localparam int HR_W   = 7;
   localparam int MIN_W  = 6;
   localparam int SEC_W  = 6;

   // register stages of the time split after the capture stage
   localparam int TIME_LAT = 4;

endpackage

### design/packet_checksum_and_time_checker.sv
// ---------------------------------------------------------------------------
// packet_checksum_and_time_checker
// Byte-wise packet checker: range sum, two's complement checksum compare,
// length check and Q14 timestamp decode, one item out per packet.
// ---------------------------------------------------------------------------
// pipeline: from acceptance of the last byte to rsp_valid, one
// capture stage and four time split stages
// throughput: one byte per cycle; the result pipe and the input stall only
// while a result waits with rsp_ready low
// reset: synchronous, restores register defaults and clears packet state;
// no clearing pass, the block accepts bytes in the cycle after reset
// ---------------------------------------------------------------------------
module packet_checksum_and_time_checker
   import pctc_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT,
   localparam int CNT_W = $clog2(MAX_BYTES + 1)
)
(
   input  logic             clock,
   input  logic             reset,

   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [10:0]      csr_write_data,

   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,

   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CNT_W-1:0] rsp_byte_count,
   output logic [19:0]      rsp_sum_total,
   output logic [7:0]       rsp_computed_checksum,
   output logic [7:0]       rsp_received_checksum,
   output logic [1:0]       rsp_checksum_status,
   output logic             rsp_length_mismatch,
   output logic             rsp_time_valid,
   output logic [SOD_W-1:0] rsp_seconds_of_day,
   output logic [HR_W-1:0]  rsp_hours,
   output logic [MIN_W-1:0] rsp_minutes,
   output logic [SEC_W-1:0] rsp_seconds,
   output logic [13:0]      rsp_fraction
);

   localparam int PIPE_DEPTH = TIME_LAT + 1;
   localparam int CMP_W      = (CNT_W > 12) ? CNT_W : 12;

   typedef enum logic [2:0] {
      REG_DATA_ONLY = 3'd0,
      REG_SUM_BEGIN = 3'd1,
      REG_SUM_END   = 3'd2,
      REG_CK_POS    = 3'd3,
      REG_TS_POS    = 3'd4,
      REG_EXP_LEN   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      CK_ABSENT   = 2'd0,
      CK_MATCH    = 2'd1,
      CK_MISMATCH = 2'd2
   } ck_status_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [19:0]      sum;
      logic [7:0]       ck;
      logic [7:0]       recv;
      ck_status_type    status;
      logic             len_mis;
      logic             tvalid;
      logic [SOD_W-1:0] sod;
      logic [13:0]      frac;
   } snap_type;

   localparam logic [9:0]  SUM_BEGIN_RST = 10'd4;
   localparam logic [9:0]  SUM_END_RST   = 10'd68;
   localparam logic [9:0]  CK_POS_RST    = 10'd68;
   localparam logic [9:0]  TS_POS_RST    = 10'd48;
   localparam logic [10:0] EXP_LEN_RST   = 11'd69;
   localparam logic [19:0] SUM_MAX       = 20'hFFFFF;
   localparam logic [CMP_W-1:0] TS_BYTES = CMP_W'(4);

   // configuration
   logic        data_only_ff;
   logic [9:0]  sum_begin_ff, sum_end_ff, ck_pos_ff, ts_pos_ff;
   logic [10:0] exp_len_ff;

   // packet state
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [19:0]      sum_ff, sum_in;
   logic [7:0]       held_ck_ff, held_ck_in;
   logic             ck_seen_ff, ck_seen_in;
   logic [31:0]      tw_ff, tw_in;

   logic             advance, accept;
   logic             in_range, sum_hit, ts_hit;
   logic [CMP_W-1:0] pos_x, ts_off, count_x;
   logic [20:0]      sum_add;
   logic [CNT_W-1:0] count_new;
   logic [19:0]      sum_new;
   logic [7:0]       held_new;
   logic             seen_new;
   logic [31:0]      tw_new;

   snap_type         snap_in;
   snap_type         snap_ff [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0] vld_ff;

   logic [HR_W-1:0]  hours;
   logic [MIN_W-1:0] minutes;
   logic [SEC_W-1:0] seconds;

   assign advance   = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_only_ff <= 1'b0;
         sum_begin_ff <= SUM_BEGIN_RST;
         sum_end_ff   <= SUM_END_RST;
         ck_pos_ff    <= CK_POS_RST;
         ts_pos_ff    <= TS_POS_RST;
         exp_len_ff   <= EXP_LEN_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DATA_ONLY: data_only_ff <= csr_write_data[0];
            REG_SUM_BEGIN: sum_begin_ff <= csr_write_data[9:0];
            REG_SUM_END:   sum_end_ff   <= csr_write_data[9:0];
            REG_CK_POS:    ck_pos_ff    <= csr_write_data[9:0];
            REG_TS_POS:    ts_pos_ff    <= csr_write_data[9:0];
            REG_EXP_LEN:   exp_len_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // per-byte update
   always_comb begin
      pos_x    = CMP_W'(pos_ff);
      in_range = pos_ff < CNT_W'(MAX_BYTES);
      sum_hit  = data_only_ff ||
                 (pos_x >= CMP_W'(sum_begin_ff) && pos_x < CMP_W'(sum_end_ff));
      ts_off   = pos_x - CMP_W'(ts_pos_ff);
      ts_hit   = !data_only_ff && pos_x >= CMP_W'(ts_pos_ff) && ts_off < TS_BYTES;
      sum_add  = {1'b0, sum_ff} + 21'(req_data_byte);

      count_new = pos_ff;
      sum_new   = sum_ff;
      held_new  = held_ck_ff;
      seen_new  = ck_seen_ff;
      tw_new    = tw_ff;
      if (in_range) begin
         count_new = pos_ff + CNT_W'(1);
         if (sum_hit) begin
            sum_new = sum_add[20] ? SUM_MAX : sum_add[19:0];
         end
         if (!data_only_ff && pos_x == CMP_W'(ck_pos_ff)) begin
            held_new = req_data_byte;
            seen_new = 1'b1;
         end
         if (ts_hit) begin
            case (ts_off[1:0])
               2'd0:    tw_new[7:0]   = tw_ff[7:0]   | req_data_byte;
               2'd1:    tw_new[15:8]  = tw_ff[15:8]  | req_data_byte;
               2'd2:    tw_new[23:16] = tw_ff[23:16] | req_data_byte;
               default: tw_new[31:24] = tw_ff[31:24] | req_data_byte;
            endcase
         end
      end

      if (req_last_byte) begin
         pos_in     = '0;
         sum_in     = '0;
         held_ck_in = '0;
         ck_seen_in = 1'b0;
         tw_in      = '0;
      end else begin
         pos_in     = count_new;
         sum_in     = sum_new;
         held_ck_in = held_new;
         ck_seen_in = seen_new;
         tw_in      = tw_new;
      end

      // result snapshot
      count_x         = CMP_W'(count_new);
      snap_in.count   = count_new;
      snap_in.sum     = sum_new;
      snap_in.ck      = 8'(8'd0 - sum_new[7:0]);
      snap_in.recv    = '0;
      snap_in.status  = CK_ABSENT;
      snap_in.len_mis = count_x != CMP_W'(exp_len_ff);
      snap_in.tvalid  = 1'b0;
      snap_in.sod     = '0;
      snap_in.frac    = '0;
      if (!data_only_ff) begin
         if (seen_new) begin
            snap_in.recv   = held_new;
            snap_in.status = (held_new == snap_in.ck) ? CK_MATCH : CK_MISMATCH;
         end
         if (count_x >= CMP_W'(ts_pos_ff) + TS_BYTES) begin
            snap_in.tvalid = 1'b1;
            snap_in.sod    = tw_new[31:14];
            snap_in.frac   = tw_new[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         held_ck_ff <= '0;
         ck_seen_ff <= 1'b0;
         tw_ff      <= '0;
         vld_ff     <= '0;
      end else begin
         if (accept) begin
            pos_ff     <= pos_in;
            sum_ff     <= sum_in;
            held_ck_ff <= held_ck_in;
            ck_seen_ff <= ck_seen_in;
            tw_ff      <= tw_in;
         end
         if (advance) begin
            vld_ff <= {vld_ff[PIPE_DEPTH-2:0], accept && req_last_byte};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff[0] <= snap_in;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            snap_ff[i] <= snap_ff[i-1];
         end
      end
   end

   pctc_time_split u_time_split (
      .clock   (clock),
      .enable  (advance),
      .sod     (snap_ff[0].sod),
      .hours   (hours),
      .minutes (minutes),
      .seconds (seconds)
   );

   assign rsp_valid             = vld_ff[PIPE_DEPTH-1];
   assign rsp_byte_count        = snap_ff[PIPE_DEPTH-1].count;
   assign rsp_sum_total         = snap_ff[PIPE_DEPTH-1].sum;
   assign rsp_computed_checksum = snap_ff[PIPE_DEPTH-1].ck;
   assign rsp_received_checksum = snap_ff[PIPE_DEPTH-1].recv;
   assign rsp_checksum_status   = snap_ff[PIPE_DEPTH-1].status;
   assign rsp_length_mismatch   = snap_ff[PIPE_DEPTH-1].len_mis;
   assign rsp_time_valid        = snap_ff[PIPE_DEPTH-1].tvalid;
   assign rsp_seconds_of_day    = snap_ff[PIPE_DEPTH-1].sod;
   assign rsp_hours             = hours;
   assign rsp_minutes           = minutes;
   assign rsp_seconds           = seconds;
   assign rsp_fraction          = snap_ff[PIPE_DEPTH-1].frac;

endmodule

### design/pctc_time_split.sv
// ---------------------------------------------------------------------------
// pctc_time_split
// Pipelined split of seconds of day into hours, minutes and seconds,
// using reciprocal multiplies; all stages advance together on enable.
// ---------------------------------------------------------------------------
module pctc_time_split
   import pctc_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [SOD_W-1:0] sod,
   output logic [HR_W-1:0]  hours,
   output logic [MIN_W-1:0] minutes,
   output logic [SEC_W-1:0] seconds
);

   localparam int REM_W          = 12;
   localparam int RECIP_H_W      = 20;
   localparam int RECIP_H_SHIFT  = 31;
   localparam int RECIP_M_W      = 13;
   localparam int RECIP_M_SHIFT  = 18;
   localparam int PROD_H_W       = SOD_W + RECIP_H_W;
   localparam int PROD_M_W       = REM_W + RECIP_M_W;
   localparam int HOUR_PROD_W    = HR_W + SOD_W;

   localparam logic [RECIP_H_W-1:0] RECIP_H     = 20'd596524;
   localparam logic [RECIP_M_W-1:0] RECIP_M     = 13'd4370;
   localparam logic [SOD_W-1:0]     SEC_PER_HR  = 18'd3600;
   localparam logic [REM_W-1:0]     SEC_PER_MIN = 12'd60;

   logic [PROD_H_W-1:0]    prod_h;
   logic [HOUR_PROD_W-1:0] prod_hs;
   logic [PROD_M_W-1:0]    prod_m;
   logic [REM_W-1:0]       prod_ms;

   logic [SOD_W-1:0] sod_a_ff;
   logic [HR_W-1:0]  hh_a_ff, hh_b_ff, hh_c_ff, hh_d_ff;
   logic [REM_W-1:0] rem_b_ff, rem_c_ff;
   logic [MIN_W-1:0] mm_c_ff, mm_d_ff;
   logic [SEC_W-1:0] ss_d_ff;

   logic [SOD_W-1:0] rem_in;

   assign prod_h  = PROD_H_W'(sod) * PROD_H_W'(RECIP_H);
   assign prod_hs = HOUR_PROD_W'(hh_a_ff) * HOUR_PROD_W'(SEC_PER_HR);
   assign rem_in  = sod_a_ff - prod_hs[SOD_W-1:0];
   assign prod_m  = PROD_M_W'(rem_b_ff) * PROD_M_W'(RECIP_M);
   assign prod_ms = REM_W'(mm_c_ff) * SEC_PER_MIN;

   always_ff @(posedge clock) begin
      if (enable) begin
         sod_a_ff <= sod;
         hh_a_ff  <= prod_h[RECIP_H_SHIFT +: HR_W];
         hh_b_ff  <= hh_a_ff;
         rem_b_ff <= rem_in[REM_W-1:0];
         hh_c_ff  <= hh_b_ff;
         rem_c_ff <= rem_b_ff;
         mm_c_ff  <= prod_m[RECIP_M_SHIFT +: MIN_W];
         hh_d_ff  <= hh_c_ff;
         mm_d_ff  <= mm_c_ff;
         ss_d_ff  <= SEC_W'(rem_c_ff - prod_ms);
      end
   end

   assign hours   = hh_d_ff;
   assign minutes = mm_d_ff;
   assign seconds = ss_d_ff;

endmodule
